// ===== hw/rtl/jhsp_pkg.sv =====
// ----------------------------------------------------------------------------
// jhsp_pkg
// Shared types and constants for the JPEG header size parser.
// ----------------------------------------------------------------------------
package jhsp_pkg;

    localparam int BYTE_W   = 8;
    localparam int DIM_W    = 16;
    localparam int STATUS_W = 3;
    localparam int COUNT_W  = 3;

    // result tdata: status, height, width, padded to whole bytes
    localparam int RES_BITS = STATUS_W + 2 * DIM_W;
    localparam int RES_TDATA_W = ((RES_BITS + 7) / 8) * 8;

    localparam logic [BYTE_W-1:0] MARKER_PREFIX = 8'hFF;
    localparam logic [BYTE_W-1:0] SOI_CODE      = 8'hD8;
    localparam logic [BYTE_W-1:0] SOS_CODE      = 8'hDA;
    localparam logic [BYTE_W-1:0] EOI_CODE      = 8'hD9;
    localparam logic [BYTE_W-1:0] SOF_BASE      = 8'hC0;

    // SOF header byte positions after the marker code
    localparam logic [COUNT_W-1:0] SOF_HEIGHT_HI = 3'd3;
    localparam logic [COUNT_W-1:0] SOF_HEIGHT_LO = 3'd4;
    localparam logic [COUNT_W-1:0] SOF_WIDTH_HI  = 3'd5;
    localparam logic [COUNT_W-1:0] SOF_WIDTH_LO  = 3'd6;
    localparam logic [COUNT_W-1:0] SOF_NCOMP     = 3'd7;

    typedef enum logic [2:0] {
        PH_SOI0 = 3'd0,
        PH_SOI1 = 3'd1,
        PH_SEEK = 3'd2,
        PH_FILL = 3'd3,
        PH_SOF  = 3'd4,
        PH_LEN  = 3'd5,
        PH_SKIP = 3'd6,
        PH_DONE = 3'd7
    } phase_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND      = 3'd0,
        ST_BAD_START  = 3'd1,
        ST_GARBAGE    = 3'd2,
        ST_SCAN_END   = 3'd3,
        ST_BAD_LENGTH = 3'd4,
        ST_TRUNCATED  = 3'd5
    } status_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } result_t;

    // SOF family: Cx excluding C4 (DHT), C8 (JPG) and CC (DAC)
    function automatic logic is_sof_code(input logic [BYTE_W-1:0] b);
        logic hit;
        hit = (b[7:4] == SOF_BASE[7:4]) && (b[1:0] != 2'b00 || b[3:2] == 2'b00);
        return hit;
    endfunction

endpackage

// ===== hw/rtl/jhsp_parser.sv =====
// ----------------------------------------------------------------------------
// jhsp_parser
// Marker walker state; one byte per enabled cycle, zero or one result.
// ----------------------------------------------------------------------------
module jhsp_parser
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        step,
    input  logic [jhsp_pkg::BYTE_W-1:0] data_byte,
    input  logic                        end_of_file,
    output jhsp_pkg::result_t           result
);

    jhsp_pkg::phase_t                 phase_reg,  phase_next;
    logic [jhsp_pkg::COUNT_W-1:0]     count_reg,  count_next;
    logic [jhsp_pkg::DIM_W-1:0]       skip_reg,   skip_next;
    logic [jhsp_pkg::BYTE_W-1:0]      held_reg,   held_next;
    logic [jhsp_pkg::DIM_W-1:0]       height_reg, height_next;
    logic [jhsp_pkg::DIM_W-1:0]       width_reg,  width_next;

    logic                             res_valid;
    jhsp_pkg::status_t                res_status;
    logic [jhsp_pkg::DIM_W-1:0]       word;

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        count_next  = count_reg;
        skip_next   = skip_reg;
        held_next   = held_reg;
        height_next = height_reg;
        width_next  = width_reg;
        res_valid   = 1'b0;
        res_status  = jhsp_pkg::ST_FOUND;
        word        = {held_reg, data_byte};

        unique case (phase_reg)
            jhsp_pkg::PH_SOI0:
            begin
                if (data_byte == jhsp_pkg::MARKER_PREFIX)
                    phase_next = jhsp_pkg::PH_SOI1;
                else
                begin
                    res_valid  = 1'b1;
                    res_status = jhsp_pkg::ST_BAD_START;
                end
            end
            jhsp_pkg::PH_SOI1:
            begin
                if (data_byte == jhsp_pkg::SOI_CODE)
                    phase_next = jhsp_pkg::PH_SEEK;
                else
                begin
                    res_valid  = 1'b1;
                    res_status = jhsp_pkg::ST_BAD_START;
                end
            end
            jhsp_pkg::PH_SEEK:
            begin
                if (data_byte == jhsp_pkg::MARKER_PREFIX)
                    phase_next = jhsp_pkg::PH_FILL;
                else
                begin
                    res_valid  = 1'b1;
                    res_status = jhsp_pkg::ST_GARBAGE;
                end
            end
            jhsp_pkg::PH_FILL:
            begin
                if (data_byte == jhsp_pkg::MARKER_PREFIX)
                begin
                    phase_next = jhsp_pkg::PH_FILL; // fill byte
                end
                else if (jhsp_pkg::is_sof_code(data_byte))
                begin
                    phase_next = jhsp_pkg::PH_SOF;
                    count_next = '0;
                end
                else if (data_byte == jhsp_pkg::SOS_CODE || data_byte == jhsp_pkg::EOI_CODE)
                begin
                    res_valid  = 1'b1;
                    res_status = jhsp_pkg::ST_SCAN_END;
                end
                else
                begin
                    phase_next = jhsp_pkg::PH_LEN;
                    count_next = '0;
                end
            end
            jhsp_pkg::PH_SOF:
            begin
                case (count_reg) inside
                    jhsp_pkg::SOF_HEIGHT_HI, jhsp_pkg::SOF_WIDTH_HI:
                        held_next = data_byte;
                    jhsp_pkg::SOF_HEIGHT_LO:
                        height_next = word;
                    jhsp_pkg::SOF_WIDTH_LO:
                        width_next = word;
                    jhsp_pkg::SOF_NCOMP:
                        res_valid = 1'b1;
                    default:
                        ;
                endcase
                if (count_reg != jhsp_pkg::SOF_NCOMP)
                    count_next = count_reg + jhsp_pkg::COUNT_W'(1);
            end
            jhsp_pkg::PH_LEN:
            begin
                if (count_reg == '0)
                begin
                    held_next  = data_byte;
                    count_next = jhsp_pkg::COUNT_W'(1);
                end
                else
                begin
                    count_next = '0;
                    if (word < jhsp_pkg::DIM_W'(2))
                    begin
                        res_valid  = 1'b1;
                        res_status = jhsp_pkg::ST_BAD_LENGTH;
                    end
                    else if (word == jhsp_pkg::DIM_W'(2))
                        phase_next = jhsp_pkg::PH_SEEK;
                    else
                    begin
                        skip_next  = word - jhsp_pkg::DIM_W'(2);
                        phase_next = jhsp_pkg::PH_SKIP;
                    end
                end
            end
            jhsp_pkg::PH_SKIP:
            begin
                if (skip_reg <= jhsp_pkg::DIM_W'(1))
                begin
                    skip_next  = '0;
                    phase_next = jhsp_pkg::PH_SEEK;
                end
                else
                    skip_next = skip_reg - jhsp_pkg::DIM_W'(1);
            end
            jhsp_pkg::PH_DONE:
                ;
            default:
                ;
        endcase

        if (res_valid)
            phase_next = jhsp_pkg::PH_DONE;

        if (end_of_file && !res_valid && phase_reg != jhsp_pkg::PH_DONE)
        begin
            res_valid  = 1'b1;
            res_status = jhsp_pkg::ST_TRUNCATED;
        end

        // last byte of a file always restarts the walk
        if (end_of_file)
        begin
            phase_next  = jhsp_pkg::PH_SOI0;
            count_next  = '0;
            skip_next   = '0;
            held_next   = '0;
            height_next = '0;
            width_next  = '0;
        end
    end

    // result fields
    always_comb
    begin
        result.valid  = step && res_valid;
        result.status = res_status;
        if (res_status == jhsp_pkg::ST_FOUND)
        begin
            result.height = height_reg;
            result.width  = width_reg;
        end
        else
        begin
            result.height = '0;
            result.width  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= jhsp_pkg::PH_SOI0;
            count_reg  <= '0;
            skip_reg   <= '0;
            held_reg   <= '0;
            height_reg <= '0;
            width_reg  <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            count_reg  <= count_next;
            skip_reg   <= skip_next;
            held_reg   <= held_next;
            height_reg <= height_next;
            width_reg  <= width_next;
        end
    end

endmodule

// ===== hw/rtl/jpeg_header_size_parser_core.sv =====
// Path: a byte goes from the input register through the parser to the result register.
// Throughput: one byte per cycle; the input register refills in the same
// cycle that the parser consumes it, and the result register parts the sides.
// Stalls come only from m_tready held low while a result waits.
// Reset: asynchronous, active low; parser returns to expecting the SOI marker.
// ----------------------------------------------------------------------------
// jpeg_header_size_parser_core
// Streams a JPEG file and reports SOF height and width, or a failure code.
// ----------------------------------------------------------------------------
module jpeg_header_size_parser_core
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [jhsp_pkg::BYTE_W-1:0]      s_tdata,  // [7:0] data_byte
    input  logic                             s_tlast,  // end_of_file
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [jhsp_pkg::RES_TDATA_W-1:0] m_tdata   // status, image_height, image_width
);

    logic                        in_valid_reg;
    logic [jhsp_pkg::BYTE_W-1:0] in_byte_reg;
    logic                        in_last_reg;
    logic                        advance;
    jhsp_pkg::result_t           result;

    logic                             out_valid_reg;
    logic [jhsp_pkg::RES_TDATA_W-1:0] out_data_reg;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jhsp_parser u_parser
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .data_byte   (in_byte_reg),
        .end_of_file (in_last_reg),
        .result      (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (result.valid)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (result.valid)
            out_data_reg <= jhsp_pkg::RES_TDATA_W'({result.width, result.height,
                                                    result.status});
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

`ifndef SYNTHESIS
    // failures carry zero dimensions
    a_zero_dims_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[jhsp_pkg::STATUS_W-1:0] != jhsp_pkg::ST_FOUND)
        |-> (m_tdata[jhsp_pkg::RES_TDATA_W-1:jhsp_pkg::STATUS_W] == '0))
        else $error("non-zero dimensions on a failure result");

    // status codes stay within the defined set
    a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[jhsp_pkg::STATUS_W-1:0] <= jhsp_pkg::ST_TRUNCATED))
        else $error("undefined status code");

    // an empty input register always takes a request
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !in_valid_reg |-> s_tready)
        else $error("input stalled while empty");

    // a consumed last byte that found the parser mid-file must give a result
    a_eof_result: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && in_last_reg && u_parser.phase_reg != jhsp_pkg::PH_DONE)
        |=> m_tvalid)
        else $error("last byte gave no result");
`endif

endmodule

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Streams directed and random JPEG byte files into the header size parser,
// predicts the status and SOF dimensions byte by byte, and checks every
// result in order while both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import jhsp_pkg::*;

    localparam logic [BYTE_W-1:0] APP0_CODE  = 8'hE0;
    localparam logic [BYTE_W-1:0] DHT_CODE   = 8'hC4;
    localparam logic [BYTE_W-1:0] JPG_CODE   = 8'hC8;
    localparam logic [BYTE_W-1:0] DAC_CODE   = 8'hCC;
    localparam logic [BYTE_W-1:0] NULL_CODE  = 8'h00;
    localparam logic [BYTE_W-1:0] SOF2_CODE  = 8'hC2;
    localparam logic [BYTE_W-1:0] SOF15_CODE = 8'hCF;

    localparam int TARGET_BYTES = 900;
    localparam int DRAIN_CYCLES = 10;

    typedef struct {
        status_t          status;
        logic [DIM_W-1:0] height;
        logic [DIM_W-1:0] width;
    } dims_result_t;

    class header_dims_checker;
        phase_t             phase;
        logic [COUNT_W-1:0] hdr_idx;
        logic [DIM_W-1:0]   skip_left;
        logic [BYTE_W-1:0]  high_byte;
        logic [DIM_W-1:0]   height_q;
        logic [DIM_W-1:0]   width_q;
        dims_result_t       pending_dims[$];
        int                 errors;

        function new();
            errors = 0;
            clear_state();
        endfunction

        static function bit is_frame_code(input logic [BYTE_W-1:0] b);
            return b[7:4] == SOF_BASE[7:4] && b != DHT_CODE && b != JPG_CODE
                   && b != DAC_CODE;
        endfunction

        function void clear_state();
            phase     = PH_SOI0;
            hdr_idx   = '0;
            skip_left = '0;
            high_byte = '0;
            height_q  = '0;
            width_q   = '0;
        endfunction

        // returns 1 when the byte was parsed rather than ignored
        function bit note_byte(input logic [BYTE_W-1:0] b, input logic last);
            bit               was_done;
            bit               has_res;
            status_t          st;
            logic [DIM_W-1:0] word;
            dims_result_t     r;
            was_done = (phase == PH_DONE);
            has_res  = 1'b0;
            st       = ST_FOUND;
            case (phase)
                PH_SOI0:
                begin
                    if (b == MARKER_PREFIX)
                        phase = PH_SOI1;
                    else
                    begin
                        has_res = 1'b1;
                        st      = ST_BAD_START;
                    end
                end
                PH_SOI1:
                begin
                    if (b == SOI_CODE)
                        phase = PH_SEEK;
                    else
                    begin
                        has_res = 1'b1;
                        st      = ST_BAD_START;
                    end
                end
                PH_SEEK:
                begin
                    if (b == MARKER_PREFIX)
                        phase = PH_FILL;
                    else
                    begin
                        has_res = 1'b1;
                        st      = ST_GARBAGE;
                    end
                end
                PH_FILL:
                begin
                    if (b == MARKER_PREFIX)
                    begin
                        // fill byte
                    end
                    else if (is_frame_code(b))
                    begin
                        phase   = PH_SOF;
                        hdr_idx = '0;
                    end
                    else if (b == SOS_CODE || b == EOI_CODE)
                    begin
                        has_res = 1'b1;
                        st      = ST_SCAN_END;
                    end
                    else
                    begin
                        phase   = PH_LEN;
                        hdr_idx = '0;
                    end
                end
                PH_SOF:
                begin
                    case (hdr_idx)
                        SOF_HEIGHT_HI, SOF_WIDTH_HI: high_byte = b;
                        SOF_HEIGHT_LO: height_q = {high_byte, b};
                        SOF_WIDTH_LO:  width_q  = {high_byte, b};
                        SOF_NCOMP:
                        begin
                            has_res = 1'b1;
                            st      = ST_FOUND;
                        end
                        default: ;
                    endcase
                    if (hdr_idx != SOF_NCOMP) hdr_idx = hdr_idx + 1'b1;
                end
                PH_LEN:
                begin
                    if (hdr_idx == '0)
                    begin
                        high_byte = b;
                        hdr_idx   = 3'd1;
                    end
                    else
                    begin
                        word    = {high_byte, b};
                        hdr_idx = '0;
                        if (word < 16'd2)
                        begin
                            has_res = 1'b1;
                            st      = ST_BAD_LENGTH;
                        end
                        else if (word == 16'd2)
                        begin
                            phase = PH_SEEK;
                        end
                        else
                        begin
                            skip_left = word - 16'd2;
                            phase     = PH_SKIP;
                        end
                    end
                end
                PH_SKIP:
                begin
                    if (skip_left <= 16'd1)
                    begin
                        skip_left = '0;
                        phase     = PH_SEEK;
                    end
                    else
                    begin
                        skip_left = skip_left - 1'b1;
                    end
                end
                default: ;
            endcase

            if (has_res) phase = PH_DONE;
            if (last && !has_res && !was_done)
            begin
                has_res = 1'b1;
                st      = ST_TRUNCATED;
            end
            if (has_res)
            begin
                r.status = st;
                r.height = (st == ST_FOUND) ? height_q : '0;
                r.width  = (st == ST_FOUND) ? width_q : '0;
                pending_dims.push_back(r);
            end
            if (last) clear_state();
            return !was_done;
        endfunction

        function void check_result(input logic [RES_TDATA_W-1:0] word);
            dims_result_t        want;
            logic [STATUS_W-1:0] got_status;
            logic [DIM_W-1:0]    got_height;
            logic [DIM_W-1:0]    got_width;
            logic [RES_TDATA_W-RES_BITS-1:0] got_pad;
            if (pending_dims.size() == 0)
            begin
                $error("result with none expected: tdata=%h", word);
                errors++;
                return;
            end
            want       = pending_dims.pop_front();
            got_status = word[STATUS_W-1:0];
            got_height = word[STATUS_W +: DIM_W];
            got_width  = word[STATUS_W+DIM_W +: DIM_W];
            got_pad    = word[RES_TDATA_W-1:RES_BITS];
            if (got_status !== want.status)
            begin
                $error("status: expected %0d, got %0d", want.status, got_status);
                errors++;
            end
            if (got_height !== want.height)
            begin
                $error("image_height: expected %h, got %h", want.height, got_height);
                errors++;
            end
            if (got_width !== want.width)
            begin
                $error("image_width: expected %h, got %h", want.width, got_width);
                errors++;
            end
            if (got_pad !== '0)
            begin
                $error("tdata padding: expected 0, got %h", got_pad);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [BYTE_W-1:0]      s_tdata;
    logic                   s_tlast;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [RES_TDATA_W-1:0] m_tdata;

    header_dims_checker sb;
    logic [BYTE_W-1:0]  file_bytes[$];
    int                 counted_bytes;

    jpeg_header_size_parser_core u_dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("** jpeg_header_size_parser_core: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) sb.check_result(m_tdata);
    end

    // result side back-pressure: alternating free-running and stall-heavy spells
    initial
    begin : ready_gen
        int stall_left;
        int mode_left;
        int r;
        bit always_ready;
        m_tready     = 1'b0;
        stall_left   = 0;
        mode_left    = 0;
        always_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                always_ready = ($urandom_range(0, 3) == 0);
                mode_left    = $urandom_range(50, 300);
            end
            mode_left--;
            if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else if (always_ready)
            begin
                m_tready <= 1'b1;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                begin
                    m_tready <= 1'b1;
                end
                else
                begin
                    m_tready   <= 1'b0;
                    stall_left = (r < 94) ? $urandom_range(0, 2) : $urandom_range(8, 40);
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return '0;
        if (r == 1) return '1;
        return DIM_W'($urandom_range(0, 65535));
    endfunction

    function automatic void put_random(input int count);
        repeat (count) file_bytes.push_back(BYTE_W'($urandom_range(0, 255)));
    endfunction

    function automatic void put_marker(input logic [BYTE_W-1:0] code);
        file_bytes.push_back(MARKER_PREFIX);
        if ($urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 3)) file_bytes.push_back(MARKER_PREFIX);
        end
        file_bytes.push_back(code);
    endfunction

    // any segment code other than a frame, scan or end marker
    function automatic void put_segment();
        logic [BYTE_W-1:0] code;
        int                seg_len;
        do code = BYTE_W'($urandom_range(0, 255));
        while (code == MARKER_PREFIX || code == SOS_CODE || code == EOI_CODE
               || header_dims_checker::is_frame_code(code));
        seg_len = ($urandom_range(0, 39) == 0) ? $urandom_range(9, 300)
                                               : $urandom_range(2, 8);
        put_marker(code);
        file_bytes.push_back(BYTE_W'(seg_len >> 8));
        file_bytes.push_back(BYTE_W'(seg_len));
        put_random(seg_len - 2);
    endfunction

    function automatic void put_frame();
        logic [BYTE_W-1:0] code;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  w;
        do code = {SOF_BASE[7:4], 4'($urandom_range(0, 15))};
        while (!header_dims_checker::is_frame_code(code));
        h = pick_dim();
        w = pick_dim();
        put_marker(code);
        put_random(3);  // length and precision
        file_bytes.push_back(h[15:8]);
        file_bytes.push_back(h[7:0]);
        file_bytes.push_back(w[15:8]);
        file_bytes.push_back(w[7:0]);
        put_random(1);
    endfunction

    function automatic void put_start();
        file_bytes.push_back(MARKER_PREFIX);
        file_bytes.push_back(SOI_CODE);
    endfunction

    task automatic send_file();
        int gap;
        bit burst;
        bit last;
        burst = ($urandom_range(0, 4) == 0);
        foreach (file_bytes[i])
        begin
            last = (i == file_bytes.size() - 1);
            gap  = burst ? 0 : pick_gap();
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            s_tvalid <= 1'b1;
            s_tdata  <= file_bytes[i];
            s_tlast  <= last;
            @(posedge clk);
            while (!s_tready) @(posedge clk);
            void'(sb.note_byte(file_bytes[i], last));
            counted_bytes++;
        end
        file_bytes.delete();
    endtask

    task automatic make_random_file();
        int r;
        int cut;
        r = $urandom_range(0, 99);
        if (r < 65)
        begin
            put_start();
            repeat ($urandom_range(0, 3)) put_segment();
            put_frame();
            put_random($urandom_range(0, 3));
            // early end of file somewhere in the header or the bytes after it
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, file_bytes.size() - 1);
                while (file_bytes.size() > cut) void'(file_bytes.pop_back());
            end
        end
        else if (r < 74)
        begin
            put_start();
            repeat ($urandom_range(0, 1)) put_segment();
            file_bytes.push_back(MARKER_PREFIX);
            file_bytes.push_back(($urandom_range(0, 1) == 0) ? NULL_CODE : APP0_CODE);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(BYTE_W'($urandom_range(0, 1)));
            put_random($urandom_range(0, 3));
        end
        else if (r < 81)
        begin
            put_start();
            repeat ($urandom_range(0, 2)) put_segment();
            put_marker(($urandom_range(0, 1) == 0) ? SOS_CODE : EOI_CODE);
            put_random($urandom_range(0, 3));
        end
        else if (r < 88)
        begin
            put_start();
            repeat ($urandom_range(0, 2)) put_segment();
            file_bytes.push_back(BYTE_W'($urandom_range(0, 254)));
            put_random($urandom_range(0, 3));
        end
        else if (r < 93)
        begin
            file_bytes.push_back(($urandom_range(0, 1) == 0) ? MARKER_PREFIX
                                 : BYTE_W'($urandom_range(0, 254)));
            put_random($urandom_range(1, 5));
        end
        else
        begin
            put_random($urandom_range(1, 12));
        end
    endtask

    initial
    begin
        sb            = new();
        counted_bytes = 0;
        rst_n         = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        s_tlast       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // smallest good file, zero dimensions, result on the last byte
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, SOF_BASE, 8'h00, 8'h11,
                       8'h08, 8'h00, 8'h00, 8'h00, 8'h00, 8'h03};
        send_file();
        // fill bytes, empty segment, full-scale dimensions, trailing bytes ignored
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP0_CODE, 8'h00, 8'h02,
                       MARKER_PREFIX, MARKER_PREFIX, MARKER_PREFIX, SOF2_CODE, 8'hFF,
                       8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h12, 8'h34};
        send_file();
        // a one-byte skip and codes just outside the frame family
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, DHT_CODE, 8'h00, 8'h03,
                       8'hFF, MARKER_PREFIX, JPG_CODE, 8'h00, 8'h02, MARKER_PREFIX,
                       DAC_CODE, 8'h00, 8'h02, MARKER_PREFIX, SOF15_CODE, 8'h00, 8'h11,
                       8'h08, 8'hA5, 8'h5A, 8'h0F, 8'hF0, 8'h01};
        send_file();
        file_bytes = '{8'h00, MARKER_PREFIX};
        send_file();
        file_bytes = '{MARKER_PREFIX, EOI_CODE};
        send_file();
        file_bytes = '{MARKER_PREFIX, SOI_CODE, 8'h00};
        send_file();
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, SOS_CODE, 8'h00};
        send_file();
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, MARKER_PREFIX, EOI_CODE};
        send_file();
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, NULL_CODE, 8'h00, 8'h00};
        send_file();
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, DHT_CODE, 8'h00, 8'h01,
                       8'h77};
        send_file();
        // huge length cut short by end of file
        file_bytes = '{MARKER_PREFIX, SOI_CODE, MARKER_PREFIX, APP0_CODE, 8'hFF, 8'hFF};
        send_file();
        file_bytes = '{MARKER_PREFIX};
        send_file();

        while (counted_bytes < TARGET_BYTES)
        begin
            make_random_file();
            send_file();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        while (sb.pending_dims.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending_dims.size() == 0)
        begin
            $display("** jpeg_header_size_parser_core: PASSED **");
        end
        else
        begin
            $display("** jpeg_header_size_parser_core: FAILED **");
        end
        $finish;
    end

endmodule
